// ----- hw/rtl/audio_playout_volume_vu_top_defines.svh -----
// assertion macros used by the playout block checker
`ifndef AUDIO_PLAYOUT_VOLUME_VU_TOP_DEFINES_SVH
`define AUDIO_PLAYOUT_VOLUME_VU_TOP_DEFINES_SVH

// clocked assertion, disabled while reset is low
`define APVV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same form, for a plain implication written inline
`define APVV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/apvv_pkg.sv -----
// shared types, constants and helpers of the audio playout block
package apvv_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned POT_W     = 12;
  localparam int unsigned POT_LVL_W = 9;
  localparam int unsigned HOST_W    = 16;
  localparam int unsigned VOL_W     = 24;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned TICK_W    = 10;
  localparam int unsigned DAC_W     = 16;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 4;

  localparam logic [DAC_W-1:0]   MIDPOINT    = 16'h8000;
  localparam logic [DAC_W-1:0]   DAC_MASK    = 16'hFFC0;
  localparam logic [HOST_W-1:0]  HOST_SILENT = 16'h8000;
  localparam logic [HOST_W-1:0]  HOST_RESET  = 16'h8000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 3'd7;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_STREAM   = 2'd0,
    REG_MUTE     = 2'd1,
    REG_HOST_VOL = 2'd2
  } reg_idx_e;

  // requests from the item front end to the sample buffer
  typedef struct packed {
    logic wr;
    logic rd;
  } ring_req_t;

  // pot level: ((raw>>4)&0xF8) + ((raw>>3)&0x08)
  function automatic logic [POT_LVL_W-1:0] pot_level(input logic [POT_W-1:0] raw);
    logic [POT_LVL_W-1:0] hi;
    logic [POT_LVL_W-1:0] lo;
    hi = {1'b0, raw[11:7], 3'b000};
    lo = {5'b00000, raw[6], 3'b000};
    return hi + lo;
  endfunction

endpackage

// ----- hw/rtl/apvv_ring.sv -----
// sample ring buffer with write/read indices and fill tracking
module apvv_ring
  import apvv_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 1024,
  parameter int unsigned KEEP_LVL     = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ring_req_t           req_i,
  input  logic [SAMPLE_W-1:0] wr_data_i,
  output logic [SAMPLE_W-1:0] rd_data_o,
  output logic                rd_hit_o
);

  localparam int unsigned AW       = $clog2(BUFFER_DEPTH);
  localparam int unsigned SKIP_LVL = BUFFER_DEPTH - KEEP_LVL;

  logic [SAMPLE_W-1:0] mem [BUFFER_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_hit_q, rd_hit_d;
  logic [AW-1:0]       wr_idx_q, wr_idx_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic                wrapped_q, wrapped_d;
  logic [AW-1:0]       fill;
  logic                skip_hit;
  logic                drain_hit;

  // fill level, read and write index advance, and read hit
  always_comb begin
    fill      = wr_idx_q - rd_idx_q;
    skip_hit  = (DATA_W'(fill) == SKIP_LVL);
    drain_hit = (DATA_W'(fill) > KEEP_LVL);
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    wrapped_d = wrapped_q;
    if (req_i.rd) begin
      rd_idx_d = rd_idx_q + AW'(skip_hit) + AW'(drain_hit);
    end
    if (req_i.wr) begin
      wr_idx_d = wr_idx_q + AW'(1);
      if (&wr_idx_q) begin
        wrapped_d = 1'b1;
      end
    end
    // a hit marks a written entry; the top level reads a miss as zero
    rd_hit_d = wrapped_q || (rd_idx_q < wr_idx_q);
  end

  // index and fill state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      rd_idx_q  <= '0;
      wrapped_q <= 1'b0;
      rd_hit_q  <= 1'b0;
    end else begin
      wr_idx_q  <= wr_idx_d;
      rd_idx_q  <= rd_idx_d;
      wrapped_q <= wrapped_d;
      if (req_i.rd) begin
        rd_hit_q <= rd_hit_d;
      end
    end
  end

  // sample memory, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[wr_idx_q] <= wr_data_i;
    end
    if (req_i.rd) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_hit_o  = rd_hit_q;

endmodule

// ----- hw/rtl/audio_playout_volume_vu_top.sv -----
// top level of the audio playout engine with volume scaling and vu metering
//
// Takes one transaction per clock on the input channel while in_ready is high. A
// write (cmd 0) stores a sample in the ring buffer and gives no result. A tick
// (cmd 1) gives one result. The accepting edge loads the registered buffer read
// together with the tick's control. The volume multiply, vu accumulation and dac
// formatting then run combinationally, and the output register loads the result
// once it is empty or its word is taken. Sustained rate is one transaction per
// cycle while the output is taken. While the output is stalled the block holds two
// ticks, one in each register, and then drops in_ready. Entries never written read
// as zero through a wrap flag and the write index, so no clearing pass runs after
// reset and the block is ready at once.
// Volume and vu level refresh on the first tick and on every 1024th after it.
module audio_playout_volume_vu_top
  import apvv_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH   = 1024,
  parameter int unsigned PACKET_SAMPLES = 32,
  parameter int unsigned PACKET_COUNT   = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [POT_W-1:0]           pot_sample_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [DAC_W-1:0]           dac_value_o,
  output logic [LEVEL_W-1:0]         vu_level_o,
  output logic                       vu_valid_o
);

  localparam int unsigned KEEP_LVL = PACKET_COUNT * PACKET_SAMPLES;

  // configuration registers
  logic              stream_q;
  logic              mute_q;
  logic [HOST_W-1:0] host_vol_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  // front end and first stage
  logic                in_acc;
  logic                tick_acc;
  ring_req_t           ring_req;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_hit;
  logic [TICK_W-1:0]   tick_cnt_q;
  logic [VOL_W-1:0]    vol_new_d;
  logic                s1_valid_q;
  logic                s1_run_q;
  logic                s1_mute_q;
  logic                s1_refresh_q;
  logic [VOL_W-1:0]    s1_vol_new_q;

  // second stage
  logic [VOL_W-1:0]          vol_q;
  logic [ACC_W-1:0]          acc_q;
  logic signed [SAMPLE_W-1:0] s_val;
  logic signed [SAMPLE_W:0]  s_ext;
  logic [SAMPLE_W:0]         mag;
  logic signed [SAMPLE_W+VOL_W:0] prod;
  logic [DAC_W-1:0]          dac_d;
  logic [ACC_W-1:0]          acc_sum;
  logic [LEVEL_W-1:0]        level_d;
  logic                      move;
  logic                      s1_fire;

  // output register
  logic               out_valid_q;
  logic [DAC_W-1:0]   dac_q;
  logic [LEVEL_W-1:0] level_q;
  logic               vu_valid_q;

  // register write decode
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q   <= 1'b0;
      mute_q     <= 1'b0;
      host_vol_q <= HOST_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STREAM:   stream_q   <= pwdata[0];
        REG_MUTE:     mute_q     <= pwdata[0];
        REG_HOST_VOL: host_vol_q <= pwdata[HOST_W-1:0];
        default:      ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_STREAM:   prdata = DATA_W'(stream_q);
      REG_MUTE:     prdata = DATA_W'(mute_q);
      REG_HOST_VOL: prdata = DATA_W'(host_vol_q);
      default:      prdata = '0;
    endcase
  end

  // handshake and buffer requests
  assign move       = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && move;
  assign in_ready_o = !s1_valid_q || move;
  assign in_acc     = in_valid_i && in_ready_o;
  assign tick_acc   = in_acc && cmd_i;
  assign ring_req.wr = in_acc && !cmd_i;
  assign ring_req.rd = tick_acc && stream_q;

  apvv_ring #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .KEEP_LVL     (KEEP_LVL)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .wr_data_i (sample_i),
    .rd_data_o (rd_data),
    .rd_hit_o  (rd_hit)
  );

  // volume reload value from host volume and pot level, full 24-bit product
  always_comb begin
    if (host_vol_q == HOST_SILENT) begin
      vol_new_d = '0;
    end else begin
      vol_new_d = VOL_W'(host_vol_q) * VOL_W'(pot_level(pot_sample_i));
    end
  end

  // first stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      tick_cnt_q <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= tick_acc;
      end
      if (tick_acc) begin
        tick_cnt_q <= tick_cnt_q + TICK_W'(1);
      end
    end
  end

  // first stage payload
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_run_q     <= stream_q;
      s1_mute_q    <= mute_q;
      s1_refresh_q <= (tick_cnt_q == '0);
      s1_vol_new_q <= vol_new_d;
    end
  end

  // scale, accumulate and format
  always_comb begin
    s_val   = (s1_run_q && rd_hit) ? $signed(rd_data) : '0;
    s_ext   = {s_val[SAMPLE_W-1], s_val};
    mag     = s_val[SAMPLE_W-1] ? unsigned'(-s_ext) : unsigned'(s_ext);
    prod    = s_val * $signed({1'b0, vol_q});
    acc_sum = acc_q + ACC_W'(mag);
    if (s1_run_q && !s1_mute_q) begin
      dac_d = prod[31:16] + MIDPOINT;
    end else begin
      dac_d = MIDPOINT;
    end
    dac_d = dac_d & DAC_MASK;
    if (|acc_sum[ACC_W-1:23]) begin
      level_d = LEVEL_MAX;
    end else begin
      level_d = acc_sum[22:20];
    end
  end

  // volume and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= '0;
      acc_q <= '0;
    end else if (s1_fire) begin
      if (s1_refresh_q) begin
        vol_q <= s1_vol_new_q;
        acc_q <= '0;
      end else begin
        acc_q <= acc_sum;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      dac_q      <= dac_d;
      level_q    <= s1_refresh_q ? level_d : '0;
      vu_valid_q <= s1_refresh_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dac_value_o = dac_q;
  assign vu_level_o  = level_q;
  assign vu_valid_o  = vu_valid_q;

endmodule

// ----- hw/rtl/apvv_checker.sv -----
// port-level checks on the playout block, bound to the top level
`include "audio_playout_volume_vu_top_defines.svh"

module apvv_checker
  import apvv_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               cmd_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [DAC_W-1:0]   dac_value_i,
  input logic [LEVEL_W-1:0] vu_level_i,
  input logic               vu_valid_i
);

  // a stalled result keeps its word
  `APVV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(dac_value_i), "stalled result changed")

  // a fresh result comes from an accepted tick that passed through the first stage
  `APVV_ASSERT_IMP(a_out_from_tick, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i && cmd_i, 2), "result without a tick")

  // refresh ticks are far apart, so two in a row cannot happen
  `APVV_ASSERT(a_refresh_gap, clk_i, rst_ni, out_valid_i && out_ready_i && vu_valid_i |=> !(out_valid_i && vu_valid_i), "back-to-back vu refresh")

  // dac word keeps its low bits clear and the level is quiet off refresh
  `APVV_ASSERT_IMP(a_out_format, clk_i, rst_ni, out_valid_i, dac_value_i[5:0] == 6'd0 && (vu_valid_i || vu_level_i == '0), "bad result format")

endmodule

bind audio_playout_volume_vu_top apvv_checker u_apvv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .dac_value_i (dac_value_o),
  .vu_level_i  (vu_level_o),
  .vu_valid_i  (vu_valid_o)
);
